// ===== hw/rtl/iol_pkg.sv =====
package iol_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FPOS_W   = 4;
    localparam int LEN_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_GET    = 3'd3,
        MODE_FIND   = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // operation broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   data;
    } cell_cmd_t;

endpackage

// ===== hw/rtl/iol_req_if.sv =====
interface iol_req_if;
    import iol_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

// ===== hw/rtl/iol_rsp_if.sv =====
interface iol_rsp_if;
    import iol_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] value_out;
    logic [FPOS_W-1:0]        found_position;
    logic [LEN_W-1:0]         length;

    modport source (output valid, output status, output value_out, output found_position,
                    output length, input ready);
    modport sink   (input valid, input status, input value_out, input found_position,
                    input length, output ready);
endinterface

// ===== hw/rtl/indexed_ordered_list.sv =====
// channel  dir  handshake        payload
// req      in   valid / ready    mode, position, value
// rsp      out  valid / ready    status, value_out, found_position, length
//
// append and insert update the list and load their result into the output register
// as they are taken; a bad position, a full list or an unused mode is answered the same way
// get, delete and find rotate the whole cell chain once past the head comparator,
// one cell per cycle in S_SCAN, then answer from S_DONE
// rst_n clears the count and control; cell contents are not reset
// a result waits in the output register while rsp is stalled; the next item is
// taken in S_IDLE once that register is free or being drained
module indexed_ordered_list #(
    parameter int DEPTH = iol_pkg::DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    iol_req_if.sink      req,
    iol_rsp_if.source    rsp
);
    import iol_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    // common width for comparing the request position with the count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] K_LAST   = IDX_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // list length and the request held during a scan
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;

    // scan step and what it has picked up
    logic [IDX_W-1:0]  k_reg, k_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  fpos_reg, fpos_next;
    logic [DATA_W-1:0] vout_reg, vout_next;

    // output register
    logic                ov_reg, ov_next;
    logic [STATUS_W-1:0] ostat_reg, ostat_next;
    logic [DATA_W-1:0]   ovalue_reg, ovalue_next;
    logic [IDX_W-1:0]    ofpos_reg, ofpos_next;
    logic [CNT_W-1:0]    olen_reg, olen_next;

    cell_cmd_t         cmd;
    logic [IDX_W-1:0]  cmd_pos;
    logic [DATA_W-1:0] head_data;

    logic              out_free;
    logic              take;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;

    // result load strobe and fields
    logic                ld;
    logic [STATUS_W-1:0] ld_stat;
    logic [DATA_W-1:0]   ld_vout;
    logic [IDX_W-1:0]    ld_fpos;
    logic [CNT_W-1:0]    ld_len;

    iol_chain #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_chain (
        .clk       (clk),
        .cmd       (cmd),
        .cmd_pos   (cmd_pos),
        .head_data (head_data)
    );

    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign take      = req.valid && req.ready;
    assign pos_ext   = CMP_W'(req.position);
    assign cnt_ext   = CMP_W'(cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        k_next     = k_reg;
        hit_next   = hit_reg;
        fpos_next  = fpos_reg;
        vout_next  = vout_reg;

        cmd.op   = CELL_HOLD;
        cmd.data = req.value;
        cmd_pos  = '0;

        ld      = 1'b0;
        ld_stat = ST_OK;
        ld_vout = '0;
        ld_fpos = '0;
        ld_len  = cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (req.mode)
                        MODE_APPEND:
                        begin
                            ld = 1'b1;
                            if (cnt_reg >= CNT_FULL)
                            begin
                                ld_stat = ST_FULL;
                            end
                            else
                            begin
                                cmd.op   = CELL_WRITE;
                                cmd_pos  = IDX_W'(cnt_reg);
                                cnt_next = cnt_reg + 1'b1;
                                ld_len   = cnt_reg + 1'b1;
                            end
                        end
                        MODE_INSERT:
                        begin
                            ld = 1'b1;
                            // position check comes before the full check
                            if (pos_ext > cnt_ext)
                            begin
                                ld_stat = ST_BADPOS;
                            end
                            else if (cnt_reg >= CNT_FULL)
                            begin
                                ld_stat = ST_FULL;
                            end
                            else
                            begin
                                cmd.op   = CELL_INSERT;
                                cmd_pos  = IDX_W'(req.position);
                                cnt_next = cnt_reg + 1'b1;
                                ld_len   = cnt_reg + 1'b1;
                            end
                        end
                        MODE_DELETE, MODE_GET:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                ld      = 1'b1;
                                ld_stat = ST_BADPOS;
                            end
                            else
                            begin
                                mode_next  = req.mode;
                                pos_next   = IDX_W'(req.position);
                                val_next   = req.value;
                                k_next     = '0;
                                hit_next   = 1'b0;
                                fpos_next  = '0;
                                vout_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        MODE_FIND:
                        begin
                            mode_next  = req.mode;
                            pos_next   = '0;
                            val_next   = req.value;
                            k_next     = '0;
                            hit_next   = 1'b0;
                            fpos_next  = '0;
                            vout_next  = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            // unused mode codes
                            ld      = 1'b1;
                            ld_stat = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // head cell holds entry k_reg this cycle
                cmd.op = CELL_ROTATE;
                if ((mode_reg == MODE_GET || mode_reg == MODE_DELETE) && k_reg == pos_reg)
                begin
                    vout_next = head_data;
                end
                if (mode_reg == MODE_FIND && !hit_reg && CNT_W'(k_reg) < cnt_reg
                    && head_data == val_reg)
                begin
                    hit_next  = 1'b1;
                    fpos_next = k_reg;
                end
                if (k_reg == K_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                // chain is back in order after a full turn
                if (out_free)
                begin
                    ld         = 1'b1;
                    state_next = S_IDLE;
                    unique case (mode_reg)
                        MODE_DELETE:
                        begin
                            cmd.op   = CELL_DELETE;
                            cmd_pos  = pos_reg;
                            cnt_next = cnt_reg - 1'b1;
                            ld_vout  = vout_reg;
                            ld_len   = cnt_reg - 1'b1;
                        end
                        MODE_GET:
                        begin
                            ld_vout = vout_reg;
                        end
                        MODE_FIND:
                        begin
                            if (hit_reg)
                            begin
                                ld_fpos = fpos_reg;
                            end
                            else
                            begin
                                ld_stat = ST_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            ld_stat = ST_BADPOS;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next     = ov_reg && !rsp.ready;
        ostat_next  = ostat_reg;
        ovalue_next = ovalue_reg;
        ofpos_next  = ofpos_reg;
        olen_next   = olen_reg;
        if (ld)
        begin
            ov_next     = 1'b1;
            ostat_next  = ld_stat;
            ovalue_next = ld_vout;
            ofpos_next  = ld_fpos;
            olen_next   = ld_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    // request copy, scan results and output payload
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        k_reg      <= k_next;
        hit_reg    <= hit_next;
        fpos_reg   <= fpos_next;
        vout_reg   <= vout_next;
        ostat_reg  <= ostat_next;
        ovalue_reg <= ovalue_next;
        ofpos_reg  <= ofpos_next;
        olen_reg   <= olen_next;
    end

    assign rsp.valid          = ov_reg;
    assign rsp.status         = ostat_reg;
    assign rsp.value_out      = ovalue_reg;
    assign rsp.found_position = FPOS_W'(ofpos_reg);
    assign rsp.length         = LEN_W'(olen_reg);
endmodule

// ===== hw/rtl/iol_cell.sv =====
module iol_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  logic                        clk,
    input  iol_pkg::cell_cmd_t          cmd,
    input  logic [IDX_W-1:0]            cmd_pos,
    input  logic [iol_pkg::DATA_W-1:0]  left_data,
    input  logic [iol_pkg::DATA_W-1:0]  right_data,
    output logic [iol_pkg::DATA_W-1:0]  data
);
    import iol_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_WRITE:
            begin
                if (MY_IDX == cmd_pos)
                begin
                    data_next = cmd.data;
                end
            end
            CELL_INSERT:
            begin
                // cells past the slot take the left neighbor
                if (MY_IDX > cmd_pos)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == cmd_pos)
                begin
                    data_next = cmd.data;
                end
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= cmd_pos)
                begin
                    data_next = right_data;
                end
            end
            CELL_ROTATE:
            begin
                data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
endmodule

// ===== hw/rtl/iol_chain.sv =====
module iol_chain #(
    parameter int DEPTH = iol_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  iol_pkg::cell_cmd_t          cmd,
    input  logic [IDX_W-1:0]            cmd_pos,
    output logic [iol_pkg::DATA_W-1:0]  head_data
);
    import iol_pkg::*;

    logic [DATA_W-1:0] cell_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = cmd.data;
        end
        else
        begin : g_mid
            assign left_d = cell_q[i-1];
        end

        // last cell wraps to the head so a rotation is circular
        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_q[0];
        end
        else
        begin : g_inner
            assign right_d = cell_q[i+1];
        end

        iol_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .cmd_pos    (cmd_pos),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_q[i])
        );
    end

    assign head_data = cell_q[0];
endmodule

// ===== tb/sv/iol_list_check.sv =====
module iol_list_check #(
    parameter int DEPTH = iol_pkg::DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    iol_req_if   req,
    iol_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);
    import iol_pkg::*;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] value_out;
        logic [FPOS_W-1:0]        found_position;
        logic [LEN_W-1:0]         length;
    } list_result_t;

    // own copy of the list
    logic signed [DATA_W-1:0] cells [DEPTH];
    int                       fill;
    list_result_t             expected_q [$];
    int                       errors;

    // apply one request to the list copy and return its result
    function automatic list_result_t apply_request(input logic [MODE_W-1:0] mode,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] val);
        list_result_t r;
        int           i;
        logic         hit;
        r = '{ST_OK, '0, '0, '0};
        hit = 1'b0;
        case (mode)
            MODE_APPEND:
            begin
                if (fill >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    cells[fill] = val;
                    fill++;
                end
            end
            MODE_INSERT:
            begin
                if (pos > fill)
                begin
                    r.status = ST_BADPOS;
                end
                else if (fill >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    for (i = fill; i > pos; i--)
                    begin
                        cells[i] = cells[i-1];
                    end
                    cells[pos] = val;
                    fill++;
                end
            end
            MODE_DELETE:
            begin
                if (pos >= fill)
                begin
                    r.status = ST_BADPOS;
                end
                else
                begin
                    r.value_out = cells[pos];
                    for (i = pos; i + 1 < fill; i++)
                    begin
                        cells[i] = cells[i+1];
                    end
                    fill--;
                end
            end
            MODE_GET:
            begin
                if (pos >= fill)
                    r.status = ST_BADPOS;
                else
                    r.value_out = cells[pos];
            end
            MODE_FIND:
            begin
                for (i = 0; i < fill && !hit; i++)
                begin
                    if (cells[i] == val)
                    begin
                        hit = 1'b1;
                        r.found_position = FPOS_W'(i);
                    end
                end
                if (!hit)
                    r.status = ST_NOTFOUND;
            end
            default:
            begin
                r.status = ST_BADPOS;
            end
        endcase
        r.length = LEN_W'(fill);
        return r;
    endfunction

    function automatic void report(input string field, input longint exp_v,
                                   input longint act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        errors++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            fill = 0;
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_q.push_back(apply_request(req.mode, req.position, req.value));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, rsp.status);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.status !== want.status)
                        report("status", want.status, rsp.status);
                    if (rsp.value_out !== want.value_out)
                        report("value_out", want.value_out, rsp.value_out);
                    if (rsp.found_position !== want.found_position)
                        report("found_position", want.found_position, rsp.found_position);
                    if (rsp.length !== want.length)
                        report("length", want.length, rsp.length);
                end
            end
            fail_count <= errors;
            pending <= expected_q.size();
        end
    end

endmodule

// ===== tb/sv/indexed_ordered_list_tb.sv =====
module indexed_ordered_list_tb;
    import iol_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1900;
    // slowest item is a full chain rotation, plus the longest receiver stall and
    // sender gap, taken many times over
    localparam int IDLE_LIMIT   = 2000;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    // kinds of random stretches: grow the list, shrink it, or mix
    typedef enum int {
        FILL_PHASE,
        DRAIN_PHASE,
        MIXED_PHASE
    } phase_kind_t;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;

    iol_req_if req ();
    iol_rsp_if rsp ();

    indexed_ordered_list #(
        .DEPTH (DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // predicts every result and compares it with what comes out
    iol_list_check #(
        .DEPTH (DEPTH)
    ) list_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // values that show up again and again so that find hits often
    logic signed [DATA_W-1:0] value_pool [8] = '{
        32'sh0000_0000, 32'shFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
        32'sh0000_0001, 32'sh0000_0005, 32'sh5555_5555, 32'shAAAA_AAAA
    };

    // most recent value sent with append or insert, whether or not it was stored
    logic signed [DATA_W-1:0] last_stored = '0;
    int                       burst_left = 0;

    // receiver: alternating ready runs and stalls of random length
    int   ready_run = 0;
    logic ready_level = 1'b0;

    always @(posedge clk)
    begin
        if (ready_run == 0)
        begin
            ready_level = ~ready_level;
            if (ready_level)
                // now and then a long stretch with no stall at all
                ready_run = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                        : $urandom_range(1, 12);
            else
                // mostly short stalls, sometimes longer than a full rotation
                ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 24)
                                                        : $urandom_range(1, 3);
        end
        ready_run--;
        rsp.ready <= ready_level;
    end

    // watchdog: too long without any handshake on either side
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // offer one item and hold it until the block takes it; bursts of random
    // length are separated by random gaps, which may be empty
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic [POS_W-1:0] pos,
                             input logic signed [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid    <= 1'b1;
        req.mode     <= mode;
        req.position <= pos;
        req.value    <= val;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (mode == MODE_APPEND || mode == MODE_INSERT)
            last_stored = val;
    endtask

    initial
    begin
        phase_kind_t              phase;
        int                       phase_left;
        int                       roll;
        int                       n;
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;

        phase_left = 0;
        phase = MIXED_PHASE;
        rst_n        <= 1'b0;
        req.valid    <= 1'b0;
        req.mode     <= MODE_APPEND;
        req.position <= '0;
        req.value    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every read is out of range, find misses,
        // insert past the end is refused
        send_item(MODE_GET, 0, 0);
        send_item(MODE_DELETE, 0, 0);
        send_item(MODE_FIND, 0, 0);
        send_item(MODE_INSERT, 1, 32'sh1234_5678);

        // build a short list with the value extremes, inserting at the head
        // and exactly at the current length
        send_item(MODE_APPEND, 0, 32'sh8000_0000);
        send_item(MODE_APPEND, 0, 32'sh7FFF_FFFF);
        send_item(MODE_INSERT, 0, 32'shFFFF_FFFF);
        send_item(MODE_INSERT, 3, 32'sh0000_0000);
        send_item(MODE_INSERT, POS_MAX, 32'sh0000_0001);
        send_item(MODE_GET, 0, 0);
        send_item(MODE_GET, 3, 0);
        send_item(MODE_GET, POS_MAX, 0);

        // find a present value and a missing one
        send_item(MODE_FIND, 0, 32'sh7FFF_FFFF);
        send_item(MODE_FIND, 0, 32'sh0000_3039);

        // delete from the middle, from the tail and out of range
        send_item(MODE_DELETE, 1, 0);
        send_item(MODE_DELETE, 2, 0);
        send_item(MODE_DELETE, 2, 0);

        // unused mode codes
        for (n = int'(MODE_FIND) + 1; n <= (1 << MODE_W) - 1; n++)
            send_item(MODE_W'(n), 0, 32'shFFFF_FFFF);

        send_item(MODE_DELETE, 0, 0);

        // random part: stretches that fill the list up to full, drain it back
        // to empty, or mix all operations
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                phase = phase_kind_t'($urandom_range(0, 2));
                phase_left = $urandom_range(15, 60);
            end
            phase_left--;

            roll = $urandom_range(0, 99);
            case (phase)
                FILL_PHASE:
                    mode = (roll < 40) ? MODE_APPEND :
                           (roll < 75) ? MODE_INSERT :
                           (roll < 83) ? MODE_GET    :
                           (roll < 93) ? MODE_FIND   :
                           (roll < 97) ? MODE_DELETE : MODE_W'(0);
                DRAIN_PHASE:
                    mode = (roll < 10) ? MODE_APPEND :
                           (roll < 18) ? MODE_INSERT :
                           (roll < 60) ? MODE_DELETE :
                           (roll < 75) ? MODE_GET    :
                           (roll < 95) ? MODE_FIND   : MODE_W'(0);
                default:
                    mode = (roll < 20) ? MODE_APPEND :
                           (roll < 40) ? MODE_INSERT :
                           (roll < 60) ? MODE_DELETE :
                           (roll < 75) ? MODE_GET    :
                           (roll < 95) ? MODE_FIND   : MODE_W'(0);
            endcase
            // the tail of each choice above stands for an unused code
            if (roll >= 95 || (phase == FILL_PHASE && roll >= 97))
                mode = MODE_W'($urandom_range(int'(MODE_FIND) + 1, (1 << MODE_W) - 1));

            // positions lean small so that deletes still land on a short list
            roll = $urandom_range(0, 9);
            if (roll < 6)
                pos = POS_W'($urandom_range(0, 3));
            else if (roll < 9)
                pos = POS_W'($urandom_range(0, DEPTH));
            else
                pos = POS_W'($urandom_range(0, POS_MAX));

            roll = $urandom_range(0, 9);
            if (mode == MODE_FIND && roll < 4)
                val = last_stored;
            else if (roll < 8 - ((mode == MODE_FIND) ? 0 : 3))
                val = value_pool[$urandom_range(0, 7)];
            else
                val = $urandom;

            send_item(mode, pos, val);
        end
        req.valid <= 1'b0;

        // drain: wait for every expected result, then let the block settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/iol_pkg.sv
hw/rtl/iol_req_if.sv
hw/rtl/iol_rsp_if.sv
hw/rtl/iol_cell.sv
hw/rtl/iol_chain.sv
hw/rtl/indexed_ordered_list.sv
tb/sv/iol_list_check.sv
tb/sv/indexed_ordered_list_tb.sv
